// File: src/dbscan_point_clustering_assert.svh
// Assertion macros shared by the clustering block.
`ifndef DBSCAN_POINT_CLUSTERING_ASSERT_SVH
`define DBSCAN_POINT_CLUSTERING_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DPC_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DPC_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/dpc_pkg.sv
// Shared types, constants and helpers for the point clustering block.
package dpc_pkg;

    localparam int DEF_MAX_POINTS = 1024;
    localparam int DEF_COORD_BITS = 24;
    localparam int EPS_BITS       = 52;
    localparam int MINPTS_BITS    = 11;
    localparam int LABEL_BITS     = 11;
    localparam int SUM_BITS       = 64;
    localparam int AXES           = 3;

    localparam logic OP_LOAD      = 1'b0;
    localparam logic OP_FETCH     = 1'b1;
    localparam logic KIND_REPORT  = 1'b0;
    localparam logic KIND_POINT   = 1'b1;

    typedef enum logic [1:0] {
        MODE_COUNT,
        MODE_RELABEL,
        MODE_EXPAND,
        MODE_FETCH
    } pass_mode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_OUTER,
        ST_OUTER_CHK,
        ST_ISSUE,
        ST_DRAIN,
        ST_POP,
        ST_POP_WAIT,
        ST_SCAN,
        ST_SCAN_CHK
    } eng_state_t;

    typedef struct packed {
        logic valid;
        logic capture;
        logic tail;
    } tok_ctl_t;

    function automatic logic [SUM_BITS-1:0] sat_add(input logic [SUM_BITS-1:0] a,
                                                    input logic [SUM_BITS-1:0] b);
        logic [SUM_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SUM_BITS] ? {SUM_BITS{1'b1}} : s[SUM_BITS-1:0];
    endfunction

endpackage

// File: src/dpc_cell.sv
// One axis cell of the distance chain: coordinate store, squared term, running sum.
module dpc_cell
    import dpc_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_POINTS,
    parameter int CB    = DEF_COORD_BITS,
    parameter int IDXW  = $clog2(DEF_MAX_POINTS),
    parameter int AXIS  = 0
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_en,
    input  logic [IDXW-1:0]                wr_addr,
    input  logic [CB-1:0]                  wr_data,
    input  tok_ctl_t                       ctl_in,
    input  logic [IDXW-1:0]                idx_in,
    input  logic [SUM_BITS-1:0]            sum_in,
    input  logic [AXES-1:0][CB-1:0]        crd_in,
    output tok_ctl_t                       ctl_out,
    output logic [IDXW-1:0]                idx_out,
    output logic [SUM_BITS-1:0]            sum_out,
    output logic [AXES-1:0][CB-1:0]        crd_out
);

    logic [CB-1:0]              mem [DEPTH];
    logic [CB-1:0]              rd_reg;
    logic [CB-1:0]              p_reg;

    tok_ctl_t                   ctl1_reg, ctl2_reg, ctl3_reg;
    logic [IDXW-1:0]            idx1_reg, idx2_reg, idx3_reg;
    logic [SUM_BITS-1:0]        sum1_reg, sum2_reg, sum3_reg;
    logic [AXES-1:0][CB-1:0]    crd1_reg, crd2_reg, crd3_reg;
    logic [SUM_BITS-1:0]        sq_reg;

    logic signed [CB:0]         diff;
    logic [CB:0]                mag;
    logic [2*CB+1:0]            prod;
    logic [AXES-1:0][CB-1:0]    crd_mod;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_reg <= mem[idx_in];
    end

    always_comb
    begin
        diff    = $signed({p_reg[CB-1], p_reg}) - $signed({rd_reg[CB-1], rd_reg});
        mag     = diff[CB] ? (CB+1)'(-diff) : diff;
        prod    = mag * mag;
        crd_mod = crd1_reg;
        crd_mod[AXIS] = rd_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
        end
        else
        begin
            ctl1_reg <= ctl_in;
            ctl2_reg <= ctl1_reg;
            ctl3_reg <= ctl2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        idx1_reg <= idx_in;
        sum1_reg <= sum_in;
        crd1_reg <= crd_in;
        if (ctl1_reg.valid && ctl1_reg.capture)
        begin
            p_reg <= rd_reg;
        end
        idx2_reg <= idx1_reg;
        sum2_reg <= sum1_reg;
        crd2_reg <= crd_mod;
        sq_reg   <= SUM_BITS'(prod);
        idx3_reg <= idx2_reg;
        sum3_reg <= sat_add(sum2_reg, sq_reg);
        crd3_reg <= crd2_reg;
    end

    assign ctl_out = ctl3_reg;
    assign idx_out = idx3_reg;
    assign sum_out = sum3_reg;
    assign crd_out = crd3_reg;

endmodule

// File: src/dpc_engine.sv
// Clustering sequencer: load, clear, core search, seed expansion and readout.
module dpc_engine
    import dpc_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_POINTS,
    parameter int CB    = DEF_COORD_BITS,
    parameter int IDXW  = $clog2(DEF_MAX_POINTS)
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic                        s_op,
    input  logic [AXES-1:0][CB-1:0]     s_crd,
    input  logic                        s_final,
    input  logic [EPS_BITS-1:0]         eps_squared,
    input  logic [MINPTS_BITS-1:0]      min_points,
    output logic                        wr_en,
    output logic [IDXW-1:0]             wr_addr,
    output tok_ctl_t                    tok_ctl,
    output logic [IDXW-1:0]             tok_idx,
    input  tok_ctl_t                    ctl_end,
    input  logic [IDXW-1:0]             idx_end,
    input  logic [SUM_BITS-1:0]         sum_end,
    input  logic [AXES-1:0][CB-1:0]     crd_end,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic                        result_kind,
    output logic [LABEL_BITS-1:0]       cluster_count,
    output logic [AXES-1:0][CB-1:0]     out_crd,
    output logic [LABEL_BITS-1:0]       cluster_label,
    output logic                        no_more,
    output logic                        last_point
);

`include "dbscan_point_clustering_assert.svh"

    localparam int CNTW = $clog2(DEPTH + 1);
    localparam int SAW  = $clog2(2 * DEPTH);
    localparam int SPW  = $clog2(2 * DEPTH + 1);
    localparam int CMPW = (CNTW > MINPTS_BITS) ? CNTW : MINPTS_BITS;

    logic [CNTW-1:0]    label_mem [DEPTH];
    logic               noise_mem [DEPTH];
    logic [IDXW-1:0]    stack_mem [2*DEPTH];

    eng_state_t         state_reg, state_next;
    pass_mode_t         mode_reg, mode_next;
    logic               from_stack_reg, from_stack_next;
    logic               clustered_reg, clustered_next;
    logic               cap_reg, cap_next;
    logic               found_reg, found_next;
    logic               more_reg, more_next;
    logic [CNTW-1:0]    count_reg, count_next;
    logic [CNTW-1:0]    readout_reg, readout_next;
    logic [CNTW-1:0]    outer_reg, outer_next;
    logic [CNTW-1:0]    issue_reg, issue_next;
    logic [CNTW-1:0]    near_cnt_reg, near_cnt_next;
    logic [CNTW-1:0]    clusters_reg, clusters_next;
    logic [CNTW-1:0]    scan_reg, scan_next;
    logic [SPW-1:0]     sp_reg, sp_next;
    logic [IDXW-1:0]    p_reg, p_next;
    logic [IDXW-1:0]    fetch_idx_reg, fetch_idx_next;
    logic               m_valid_reg, m_valid_next;

    tok_ctl_t               res_ctl_reg;
    logic [IDXW-1:0]        res_idx_reg;
    logic                   res_near_reg;
    logic [AXES-1:0][CB-1:0] res_crd_reg;
    logic [CNTW-1:0]        lab_rd_reg;
    logic                   noise_rd_reg;
    logic [IDXW-1:0]        stack_rd_reg;

    logic               out_kind_reg;
    logic [LABEL_BITS-1:0] out_count_reg;
    logic [AXES-1:0][CB-1:0] out_crd_reg;
    logic [LABEL_BITS-1:0] out_label_reg;
    logic               out_nomore_reg;
    logic               out_last_reg;

    logic               accept;
    logic               res_live;
    logic               push_req;
    logic               core;
    logic [CNTW-1:0]    cnt_base;
    logic [IDXW-1:0]    rd_addr;
    logic               lab_we;
    logic [IDXW-1:0]    lab_wa;
    logic [CNTW-1:0]    lab_wd;
    logic               noise_we;
    logic [IDXW-1:0]    noise_wa;
    logic               noise_wd;
    logic               stk_we;
    logic               out_set;
    logic               out_kind;
    logic [LABEL_BITS-1:0] out_count;
    logic [AXES-1:0][CB-1:0] out_crd_v;
    logic [LABEL_BITS-1:0] out_label;
    logic               out_nomore;
    logic               out_last;

    always_ff @(posedge clk)
    begin
        if (lab_we)
        begin
            label_mem[lab_wa] <= lab_wd;
        end
        if (noise_we)
        begin
            noise_mem[noise_wa] <= noise_wd;
        end
        if (stk_we)
        begin
            stack_mem[SAW'(sp_reg)] <= res_idx_reg;
        end
        lab_rd_reg   <= label_mem[rd_addr];
        noise_rd_reg <= noise_mem[rd_addr];
        stack_rd_reg <= stack_mem[SAW'(sp_reg - 1'b1)];
    end

    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        from_stack_next = from_stack_reg;
        clustered_next  = clustered_reg;
        cap_next        = cap_reg;
        found_next      = found_reg;
        more_next       = more_reg;
        count_next      = count_reg;
        readout_next    = readout_reg;
        outer_next      = outer_reg;
        issue_next      = issue_reg;
        near_cnt_next   = near_cnt_reg;
        clusters_next   = clusters_reg;
        scan_next       = scan_reg;
        sp_next         = sp_reg;
        p_next          = p_reg;
        fetch_idx_next  = fetch_idx_reg;
        m_valid_next    = (m_valid_reg && !m_tready) ? 1'b1 : 1'b0;

        tok_ctl     = '0;
        tok_idx     = p_reg;
        wr_en       = 1'b0;
        wr_addr     = IDXW'(count_reg);
        cnt_base    = clustered_reg ? '0 : count_reg;
        rd_addr     = idx_end;
        lab_we      = 1'b0;
        lab_wa      = res_idx_reg;
        lab_wd      = clusters_reg;
        noise_we    = 1'b0;
        noise_wa    = res_idx_reg;
        noise_wd    = 1'b0;
        stk_we      = 1'b0;
        push_req    = 1'b0;
        core        = 1'b0;
        out_set     = 1'b0;
        out_kind    = KIND_POINT;
        out_count   = '0;
        out_crd_v   = '0;
        out_label   = '0;
        out_nomore  = 1'b0;
        out_last    = 1'b0;

        s_tready = (state_reg == ST_IDLE) && (!m_valid_reg || m_tready);
        accept   = s_tready && s_tvalid;

        res_live = res_ctl_reg.valid && !res_ctl_reg.capture;
        if (res_live)
        begin
            unique case (mode_reg)
                MODE_COUNT:
                begin
                    if (res_near_reg)
                    begin
                        near_cnt_next = near_cnt_reg + 1'b1;
                    end
                end
                MODE_RELABEL:
                begin
                    if (res_near_reg)
                    begin
                        lab_we   = 1'b1;
                        noise_we = 1'b1;
                        push_req = 1'b1;
                    end
                end
                MODE_EXPAND:
                begin
                    if (res_near_reg && lab_rd_reg == '0 && !noise_rd_reg)
                    begin
                        lab_we   = 1'b1;
                        push_req = 1'b1;
                    end
                end
                MODE_FETCH:
                begin
                end
            endcase
        end
        if (push_req && sp_reg < SPW'(2 * DEPTH))
        begin
            stk_we  = 1'b1;
            sp_next = sp_reg + 1'b1;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (s_op == OP_LOAD)
                    begin
                        if (clustered_reg)
                        begin
                            clustered_next = 1'b0;
                            readout_next   = '0;
                        end
                        count_next = cnt_base;
                        if (cnt_base < CNTW'(DEPTH))
                        begin
                            wr_en      = 1'b1;
                            wr_addr    = IDXW'(cnt_base);
                            count_next = cnt_base + 1'b1;
                        end
                        if (s_final)
                        begin
                            scan_next  = '0;
                            state_next = ST_CLEAR;
                        end
                    end
                    else if (!clustered_reg)
                    begin
                        out_set    = 1'b1;
                        out_nomore = 1'b1;
                    end
                    else
                    begin
                        scan_next  = readout_reg;
                        found_next = 1'b0;
                        more_next  = 1'b0;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_CLEAR:
            begin
                if (scan_reg < count_reg)
                begin
                    lab_we    = 1'b1;
                    lab_wa    = IDXW'(scan_reg);
                    lab_wd    = '0;
                    noise_we  = 1'b1;
                    noise_wa  = IDXW'(scan_reg);
                    scan_next = scan_reg + 1'b1;
                end
                else
                begin
                    outer_next    = '0;
                    clusters_next = '0;
                    state_next    = ST_OUTER;
                end
            end
            ST_OUTER:
            begin
                rd_addr = IDXW'(outer_reg);
                if (outer_reg >= count_reg)
                begin
                    out_set        = 1'b1;
                    out_kind       = KIND_REPORT;
                    out_count      = LABEL_BITS'(clusters_reg);
                    clustered_next = 1'b1;
                    readout_next   = '0;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    state_next = ST_OUTER_CHK;
                end
            end
            ST_OUTER_CHK:
            begin
                if (lab_rd_reg == '0 && !noise_rd_reg)
                begin
                    p_next          = IDXW'(outer_reg);
                    mode_next       = MODE_COUNT;
                    from_stack_next = 1'b0;
                    near_cnt_next   = '0;
                    cap_next        = 1'b1;
                    issue_next      = '0;
                    state_next      = ST_ISSUE;
                end
                else
                begin
                    outer_next = outer_reg + 1'b1;
                    state_next = ST_OUTER;
                end
            end
            ST_ISSUE:
            begin
                if (mode_reg == MODE_FETCH)
                begin
                    tok_ctl.valid = 1'b1;
                    tok_ctl.tail  = 1'b1;
                    state_next    = ST_DRAIN;
                end
                else if (cap_reg)
                begin
                    tok_ctl.valid   = 1'b1;
                    tok_ctl.capture = 1'b1;
                    cap_next        = 1'b0;
                end
                else
                begin
                    tok_ctl.valid = 1'b1;
                    tok_idx       = IDXW'(issue_reg);
                    issue_next    = issue_reg + 1'b1;
                    if (issue_reg == count_reg - 1'b1)
                    begin
                        tok_ctl.tail = 1'b1;
                        state_next   = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                if (res_ctl_reg.valid && res_ctl_reg.tail)
                begin
                    unique case (mode_reg)
                        MODE_COUNT:
                        begin
                            core = CMPW'(near_cnt_next) >= CMPW'(min_points);
                            if (!core && from_stack_reg)
                            begin
                                state_next = ST_POP;
                            end
                            else if (!core)
                            begin
                                noise_we   = 1'b1;
                                noise_wa   = p_reg;
                                noise_wd   = 1'b1;
                                outer_next = outer_reg + 1'b1;
                                state_next = ST_OUTER;
                            end
                            else
                            begin
                                if (from_stack_reg)
                                begin
                                    mode_next = MODE_EXPAND;
                                end
                                else
                                begin
                                    mode_next     = MODE_RELABEL;
                                    clusters_next = clusters_reg + 1'b1;
                                    sp_next       = '0;
                                end
                                cap_next   = 1'b1;
                                issue_next = '0;
                                state_next = ST_ISSUE;
                            end
                        end
                        MODE_RELABEL, MODE_EXPAND:
                        begin
                            state_next = ST_POP;
                        end
                        MODE_FETCH:
                        begin
                            out_set      = 1'b1;
                            out_crd_v    = res_crd_reg;
                            out_label    = LABEL_BITS'(lab_rd_reg);
                            out_last     = !more_reg;
                            readout_next = CNTW'(p_reg) + 1'b1;
                            state_next   = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_POP:
            begin
                if (sp_reg == '0)
                begin
                    outer_next = outer_reg + 1'b1;
                    state_next = ST_OUTER;
                end
                else
                begin
                    sp_next    = sp_reg - 1'b1;
                    state_next = ST_POP_WAIT;
                end
            end
            ST_POP_WAIT:
            begin
                p_next          = stack_rd_reg;
                mode_next       = MODE_COUNT;
                from_stack_next = 1'b1;
                near_cnt_next   = '0;
                cap_next        = 1'b1;
                issue_next      = '0;
                state_next      = ST_ISSUE;
            end
            ST_SCAN:
            begin
                rd_addr = IDXW'(scan_reg);
                if (scan_reg >= count_reg)
                begin
                    if (found_reg)
                    begin
                        p_next     = fetch_idx_reg;
                        mode_next  = MODE_FETCH;
                        state_next = ST_ISSUE;
                    end
                    else
                    begin
                        readout_next = count_reg;
                        out_set      = 1'b1;
                        out_nomore   = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end
                else
                begin
                    state_next = ST_SCAN_CHK;
                end
            end
            ST_SCAN_CHK:
            begin
                scan_next  = scan_reg + 1'b1;
                state_next = ST_SCAN;
                if (!noise_rd_reg && found_reg)
                begin
                    more_next  = 1'b1;
                    p_next     = fetch_idx_reg;
                    mode_next  = MODE_FETCH;
                    state_next = ST_ISSUE;
                end
                else if (!noise_rd_reg)
                begin
                    found_next     = 1'b1;
                    fetch_idx_next = IDXW'(scan_reg);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_set)
        begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            mode_reg       <= MODE_COUNT;
            from_stack_reg <= 1'b0;
            clustered_reg  <= 1'b0;
            cap_reg        <= 1'b0;
            found_reg      <= 1'b0;
            more_reg       <= 1'b0;
            count_reg      <= '0;
            readout_reg    <= '0;
            outer_reg      <= '0;
            issue_reg      <= '0;
            near_cnt_reg   <= '0;
            clusters_reg   <= '0;
            scan_reg       <= '0;
            sp_reg         <= '0;
            p_reg          <= '0;
            fetch_idx_reg  <= '0;
            m_valid_reg    <= 1'b0;
            res_ctl_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            mode_reg       <= mode_next;
            from_stack_reg <= from_stack_next;
            clustered_reg  <= clustered_next;
            cap_reg        <= cap_next;
            found_reg      <= found_next;
            more_reg       <= more_next;
            count_reg      <= count_next;
            readout_reg    <= readout_next;
            outer_reg      <= outer_next;
            issue_reg      <= issue_next;
            near_cnt_reg   <= near_cnt_next;
            clusters_reg   <= clusters_next;
            scan_reg       <= scan_next;
            sp_reg         <= sp_next;
            p_reg          <= p_next;
            fetch_idx_reg  <= fetch_idx_next;
            m_valid_reg    <= m_valid_next;
            res_ctl_reg    <= ctl_end;
        end
    end

    always_ff @(posedge clk)
    begin
        res_idx_reg  <= idx_end;
        res_near_reg <= sum_end <= SUM_BITS'(eps_squared);
        res_crd_reg  <= crd_end;
        if (out_set)
        begin
            out_kind_reg   <= out_kind;
            out_count_reg  <= out_count;
            out_crd_reg    <= out_crd_v;
            out_label_reg  <= out_label;
            out_nomore_reg <= out_nomore;
            out_last_reg   <= out_last;
        end
    end

    assign m_tvalid      = m_valid_reg;
    assign result_kind   = out_kind_reg;
    assign cluster_count = out_count_reg;
    assign out_crd       = out_crd_reg;
    assign cluster_label = out_label_reg;
    assign no_more       = out_nomore_reg;
    assign last_point    = out_last_reg;

    `DPC_ASSERT_NOW(a_idle_no_token, clk, rst_n, state_reg == ST_IDLE, !tok_ctl.valid,
        "token issued while idle")
    `DPC_ASSERT_NOW(a_tail_in_drain, clk, rst_n, res_ctl_reg.valid && res_ctl_reg.tail,
        state_reg == ST_DRAIN, "pass tail outside drain")
    `DPC_ASSERT_NOW(a_push_mode, clk, rst_n, stk_we,
        mode_reg == MODE_RELABEL || mode_reg == MODE_EXPAND, "seed push outside growth")
    `DPC_ASSERT_NOW(a_out_slot_free, clk, rst_n, out_set, !m_valid_reg || m_tready,
        "result overwrites a pending item")

endmodule

// File: src/dbscan_point_clustering.sv
// Top level of the density clustering block: register port, axis chain and sequencer.
//
//  channel   dir   handshake               contents
//  s_*       in    s_tvalid/s_tready       tdata x,y,z; tuser operation; tlast final point
//  m_*       out   m_tvalid/m_tready       tdata count,x,y,z,label,no_more; tuser kind;
//                                          tlast last point
//  APB       in    psel/penable/pready     eps_squared at 0, min_points at 8
//
//  A load or an unclustered fetch is handled while the block stays idle. Clustering first
//  clears the labels, then checks each outer point or popped seed; each distance pass
//  issues a capture token and one token per point through the three axis cells and the
//  result register. Each visited point and popped seed runs a counting pass, and a second
//  pass when it is core. A clustered fetch scans the points, then issues one fetch token.
//  Reset clears all control state; stores are written before use. The input stalls while
//  clustering or a fetch runs, and while a result waits and m_tready is low.
module dbscan_point_clustering
    import dpc_pkg::*;
#(
    parameter int MAX_POINTS = DEF_MAX_POINTS,
    parameter int COORD_BITS = DEF_COORD_BITS
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    // point_x, point_y, point_z
    input  logic [((3*COORD_BITS+7)/8)*8-1:0] s_tdata,
    // operation
    input  logic                s_tuser,
    input  logic                s_tlast,
    output logic                m_tvalid,
    input  logic                m_tready,
    // cluster_count, out_x, out_y, out_z, cluster_label, no_more
    output logic [((3*COORD_BITS+2*LABEL_BITS+1+7)/8)*8-1:0] m_tdata,
    // result_kind
    output logic                m_tuser,
    output logic                m_tlast,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [63:0]         pwdata,
    output logic [63:0]         prdata,
    output logic                pready
);

    localparam int IDXW = $clog2(MAX_POINTS);
    localparam int MDW  = ((3*COORD_BITS+2*LABEL_BITS+1+7)/8)*8;

    logic [EPS_BITS-1:0]    eps_reg;
    logic [MINPTS_BITS-1:0] minp_reg;

    tok_ctl_t                       ctl_w [AXES+1];
    logic [IDXW-1:0]                idx_w [AXES+1];
    logic [SUM_BITS-1:0]            sum_w [AXES+1];
    logic [AXES-1:0][COORD_BITS-1:0] crd_w [AXES+1];

    logic [AXES-1:0][COORD_BITS-1:0] s_crd;
    logic [AXES-1:0][COORD_BITS-1:0] out_crd;
    logic                   wr_en;
    logic [IDXW-1:0]        wr_addr;
    logic                   result_kind;
    logic [LABEL_BITS-1:0]  cluster_count;
    logic [LABEL_BITS-1:0]  cluster_label;
    logic                   no_more;
    logic                   last_point;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg  <= EPS_BITS'(65536);
            minp_reg <= MINPTS_BITS'(4);
        end
        else if (psel && penable && pwrite && pready)
        begin
            if (paddr[3])
            begin
                minp_reg <= pwdata[MINPTS_BITS-1:0];
            end
            else
            begin
                eps_reg <= pwdata[EPS_BITS-1:0];
            end
        end
    end

    assign pready = 1'b1;
    assign prdata = paddr[3] ? 64'(minp_reg) : 64'(eps_reg);

    assign s_crd = s_tdata[3*COORD_BITS-1:0];
    assign sum_w[0] = '0;
    assign crd_w[0] = '0;

    for (genvar a = 0; a < AXES; a++)
    begin : g_cell
        dpc_cell #(
            .DEPTH (MAX_POINTS),
            .CB    (COORD_BITS),
            .IDXW  (IDXW),
            .AXIS  (a)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .wr_en   (wr_en),
            .wr_addr (wr_addr),
            .wr_data (s_crd[a]),
            .ctl_in  (ctl_w[a]),
            .idx_in  (idx_w[a]),
            .sum_in  (sum_w[a]),
            .crd_in  (crd_w[a]),
            .ctl_out (ctl_w[a+1]),
            .idx_out (idx_w[a+1]),
            .sum_out (sum_w[a+1]),
            .crd_out (crd_w[a+1])
        );
    end

    dpc_engine #(
        .DEPTH (MAX_POINTS),
        .CB    (COORD_BITS),
        .IDXW  (IDXW)
    ) u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_op          (s_tuser),
        .s_crd         (s_crd),
        .s_final       (s_tlast),
        .eps_squared   (eps_reg),
        .min_points    (minp_reg),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .tok_ctl       (ctl_w[0]),
        .tok_idx       (idx_w[0]),
        .ctl_end       (ctl_w[AXES]),
        .idx_end       (idx_w[AXES]),
        .sum_end       (sum_w[AXES]),
        .crd_end       (crd_w[AXES]),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .result_kind   (result_kind),
        .cluster_count (cluster_count),
        .out_crd       (out_crd),
        .cluster_label (cluster_label),
        .no_more       (no_more),
        .last_point    (last_point)
    );

    assign m_tdata = MDW'({no_more, cluster_label, out_crd, cluster_count});
    assign m_tuser = result_kind;
    assign m_tlast = last_point;

endmodule
